// ===== hw/rtl/tof_range_to_point_unit_assert.svh =====
// Assertion macros for the range-to-point unit
`ifndef TOF_RANGE_TO_POINT_UNIT_ASSERT_SVH
`define TOF_RANGE_TO_POINT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TOF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tof_range_to_point_unit: assertion failed");
`define TOF_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("tof_range_to_point_unit: forbidden condition seen");
`else
`define TOF_ASSERT(lbl, prop)
`define TOF_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/tof_pkg.sv =====
// Package: widths, payload types and register codes of the range-to-point unit
`default_nettype none
package tof_pkg;
   localparam int PIXEL_BITS     = 12;
   localparam int DISTANCE_BITS  = 16;
   localparam int REG_BITS       = 20;
   localparam int OUT_BITS       = 24;
   localparam int FRAC_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;

   localparam int UPIX_BITS = PIXEL_BITS + FRAC_BITS;
   localparam int MAG_BITS  = (UPIX_BITS > REG_BITS) ? UPIX_BITS : REG_BITS;
   localparam int SQ_BITS   = 2 * MAG_BITS + 2;
   localparam int PP_BITS   = 2 * DISTANCE_BITS + 2 + REG_BITS;
   localparam int T_BITS    = 2 * DISTANCE_BITS + 2 + 2 * REG_BITS;
   localparam int Q_BITS    = 2 * DISTANCE_BITS + 2;
   localparam int DV_BITS   = SQ_BITS + Q_BITS;
   localparam int W_BITS    = DISTANCE_BITS + 1;
   localparam int RT_BITS   = 2 * W_BITS + 1;
   localparam int P_BITS    = MAG_BITS + DISTANCE_BITS;
   localparam int N_BITS    = P_BITS + 2;
   localparam int ACC_BITS  = (N_BITS > REG_BITS + 1 + OUT_BITS) ? N_BITS
                                                                 : REG_BITS + 1 + OUT_BITS;

   localparam logic [REG_BITS-1:0] FOCAL_RESET = REG_BITS'(64000);
   localparam logic [REG_BITS-1:0] CCOL_RESET  = REG_BITS'(22528);
   localparam logic [REG_BITS-1:0] CROW_RESET  = REG_BITS'(18432);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FOCAL = 2'd0,
      CSR_CCOL  = 2'd1,
      CSR_CROW  = 2'd2,
      CSR_MODE  = 2'd3
   } tof_csr_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]    pixel_col;
      logic [PIXEL_BITS-1:0]    pixel_row;
      logic [DISTANCE_BITS-1:0] distance;
   } tof_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] point_x;
      logic signed [OUT_BITS-1:0] point_y;
      logic [DISTANCE_BITS-1:0]   point_z;
   } tof_rsp_type;

   typedef struct packed {
      logic [REG_BITS-1:0] focal_length;
      logic [REG_BITS-1:0] center_col;
      logic [REG_BITS-1:0] center_row;
      logic                distance_mode;
   } tof_cfg_type;

   // per-item values that ride along the pipeline
   typedef struct packed {
      logic                     mode;
      logic [DISTANCE_BITS-1:0] range_mm;
      logic [REG_BITS-1:0]      focal;
      logic                     neg_x;
      logic                     neg_y;
      logic [MAG_BITS-1:0]      mag_x;
      logic [MAG_BITS-1:0]      mag_y;
   } tof_side_type;

   // 4 r^2 f^2 over f^2 + du^2 + dv^2
   typedef struct packed {
      logic [T_BITS-1:0]  num;
      logic [SQ_BITS-1:0] den;
   } tof_frac_type;
endpackage
`default_nettype wire

// ===== hw/rtl/tof_range_to_point_unit.sv =====
// Top level: back-projects a time-of-flight pixel and its range to a 3D point
//
//   channel   ports                              direction
//   request   req_valid, req_stall, req_data     in  (column, row, distance)
//   response  rsp_valid, rsp_stall, rsp_data     out (x, y, z in mm)
//   control   csr_wr_en, csr_index, csr_wr_data  in  (write only)
//
// One item per clock while the response is not stalled; the quotient, square root and
// lateral divide stages each resolve one bit per stage.
// Synchronous reset restores focal length 250.0, centre (88.0, 72.0) and radial mode.
// A stalled response freezes the whole pipeline; req_stall follows it directly.
`default_nettype none
module tof_range_to_point_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tof_pkg::tof_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tof_pkg::tof_rsp_type                rsp_data,
   input  logic                                csr_wr_en,
   input  logic [tof_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tof_pkg::REG_BITS-1:0]        csr_wr_data
);
   import tof_pkg::*;

   tof_cfg_type              cfg_in, cfg_ff;
   logic                     en;
   logic                     fr_valid, zs_valid;
   tof_side_type             fr_side, zs_side;
   tof_frac_type             fr_frac;
   logic [DISTANCE_BITS-1:0] zs_z;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (tof_csr_type'(csr_index))
            CSR_FOCAL: cfg_in.focal_length  = csr_wr_data;
            CSR_CCOL:  cfg_in.center_col    = csr_wr_data;
            CSR_CROW:  cfg_in.center_row    = csr_wr_data;
            CSR_MODE:  cfg_in.distance_mode = csr_wr_data[0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_length  <= FOCAL_RESET;
         cfg_ff.center_col    <= CCOL_RESET;
         cfg_ff.center_row    <= CROW_RESET;
         cfg_ff.distance_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   tof_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_frac  (fr_frac)
   );

   tof_zsolve u_zsolve (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_frac   (fr_frac),
      .out_valid (zs_valid),
      .out_side  (zs_side),
      .out_z     (zs_z)
   );

   tof_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (zs_valid),
      .in_side   (zs_side),
      .in_z      (zs_z),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/tof_front.sv =====
// Front end: offsets from principal point, squares, ray norm and scaled range product
`default_nettype none
module tof_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  tof_pkg::tof_req_type in_data,
   input  tof_pkg::tof_cfg_type cfg,
   output logic                 out_valid,
   output tof_pkg::tof_side_type out_side,
   output tof_pkg::tof_frac_type out_frac
);
   import tof_pkg::*;
`include "tof_range_to_point_unit_assert.svh"

   logic [MAG_BITS:0] ucol, urow, ccol, crow, dcol, drow;
   tof_side_type side_in;
   tof_side_type side_ff [1:4];
   logic         vld_ff  [1:4];

   logic [2*REG_BITS-1:0]      f2_in, f2_ff;
   logic [2*MAG_BITS-1:0]      mx2_in, mx2_ff, my2_in, my2_ff;
   logic [2*DISTANCE_BITS-1:0] r2_in, r2_ff;
   logic [2*DISTANCE_BITS+1:0] r4;
   logic [SQ_BITS-1:0]         sum_in, sum_ff;
   logic [PP_BITS-1:0]         plo_in, plo_ff, phi_in, phi_ff;
   tof_frac_type               frac_in, frac_ff;

   always_comb begin
      ucol = (MAG_BITS+1)'({in_data.pixel_col, FRAC_BITS'(0)});
      urow = (MAG_BITS+1)'({in_data.pixel_row, FRAC_BITS'(0)});
      ccol = (MAG_BITS+1)'(cfg.center_col);
      crow = (MAG_BITS+1)'(cfg.center_row);
      dcol = ucol - ccol;
      drow = urow - crow;
      side_in.mode     = cfg.distance_mode;
      side_in.range_mm = in_data.distance;
      side_in.focal    = (cfg.focal_length == '0) ? REG_BITS'(1) : cfg.focal_length;
      side_in.neg_x    = dcol[MAG_BITS];
      side_in.neg_y    = drow[MAG_BITS];
      side_in.mag_x    = dcol[MAG_BITS] ? MAG_BITS'(-dcol) : dcol[MAG_BITS-1:0];
      side_in.mag_y    = drow[MAG_BITS] ? MAG_BITS'(-drow) : drow[MAG_BITS-1:0];
   end

   always_comb begin
      f2_in  = side_ff[1].focal * side_ff[1].focal;
      mx2_in = side_ff[1].mag_x * side_ff[1].mag_x;
      my2_in = side_ff[1].mag_y * side_ff[1].mag_y;
      r2_in  = side_ff[1].range_mm * side_ff[1].range_mm;
   end

   always_comb begin
      r4     = {r2_ff, 2'b00};
      sum_in = SQ_BITS'(f2_ff) + SQ_BITS'(mx2_ff) + SQ_BITS'(my2_ff);
      plo_in = r4 * f2_ff[REG_BITS-1:0];
      phi_in = r4 * f2_ff[2*REG_BITS-1:REG_BITS];
   end

   always_comb begin
      frac_in.num = T_BITS'(plo_ff) + (T_BITS'(phi_ff) << REG_BITS);
      frac_in.den = sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 4; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= in_valid;
         for (int i = 2; i <= 4; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= side_in;
         for (int i = 2; i <= 4; i++) side_ff[i] <= side_ff[i-1];
         f2_ff   <= f2_in;
         mx2_ff  <= mx2_in;
         my2_ff  <= my2_in;
         r2_ff   <= r2_in;
         sum_ff  <= sum_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         frac_ff <= frac_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_side  = side_ff[4];
   assign out_frac  = frac_ff;

   `TOF_NEVER(a_front_den_zero, vld_ff[4] && (frac_ff.den == '0))
endmodule
`default_nettype wire

// ===== hw/rtl/tof_zsolve.sv =====
// Depth solver: pipelined quotient, pipelined square root, rounding and mode select
`default_nettype none
module tof_zsolve (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  tof_pkg::tof_side_type             in_side,
   input  tof_pkg::tof_frac_type             in_frac,
   output logic                              out_valid,
   output tof_pkg::tof_side_type             out_side,
   output logic [tof_pkg::DISTANCE_BITS-1:0] out_z
);
   import tof_pkg::*;
`include "tof_range_to_point_unit_assert.svh"

   typedef struct packed {
      logic [T_BITS-1:0]  rem;
      logic [Q_BITS-1:0]  quo;
      logic [SQ_BITS-1:0] den;
   } div_type;

   typedef struct packed {
      logic [RT_BITS-1:0] rem;
      logic [W_BITS-1:0]  root;
   } root_type;

   div_type      div_ff   [1:Q_BITS];
   tof_side_type dside_ff [1:Q_BITS];
   logic         dvld_ff  [1:Q_BITS];
   root_type     root_ff  [1:W_BITS];
   tof_side_type rside_ff [1:W_BITS];
   logic         rvld_ff  [1:W_BITS];

   // quotient bits, most significant first
   for (genvar k = 0; k < Q_BITS; k++) begin : g_div
      localparam int BIT = Q_BITS - 1 - k;
      div_type            div_cur, div_in;
      tof_side_type       side_cur;
      logic               vld_cur;
      logic [DV_BITS-1:0] shifted;
      if (k == 0) begin : g_first
         always_comb begin
            div_cur.rem = in_frac.num;
            div_cur.quo = '0;
            div_cur.den = in_frac.den;
         end
         assign side_cur = in_side;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign div_cur  = div_ff[k];
         assign side_cur = dside_ff[k];
         assign vld_cur  = dvld_ff[k];
      end
      always_comb begin
         div_in  = div_cur;
         shifted = DV_BITS'(div_cur.den) << BIT;
         if (shifted <= DV_BITS'(div_cur.rem)) begin
            div_in.rem      = div_cur.rem - T_BITS'(shifted);
            div_in.quo[BIT] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[k+1] <= 1'b0;
         end else if (en) begin
            dvld_ff[k+1] <= vld_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[k+1]   <= div_in;
            dside_ff[k+1] <= side_cur;
         end
      end
   end

   // integer square root of the quotient, one root bit per stage
   for (genvar j = 0; j < W_BITS; j++) begin : g_root
      localparam int BIT = W_BITS - 1 - j;
      root_type           root_cur, root_in;
      tof_side_type       side_cur;
      logic               vld_cur;
      logic [RT_BITS-1:0] trial;
      if (j == 0) begin : g_first
         always_comb begin
            root_cur.rem  = RT_BITS'(div_ff[Q_BITS].quo);
            root_cur.root = '0;
         end
         assign side_cur = dside_ff[Q_BITS];
         assign vld_cur  = dvld_ff[Q_BITS];
      end else begin : g_next
         assign root_cur = root_ff[j];
         assign side_cur = rside_ff[j];
         assign vld_cur  = rvld_ff[j];
      end
      always_comb begin
         root_in = root_cur;
         trial   = (RT_BITS'(root_cur.root) << (BIT + 1)) + (RT_BITS'(1) << (2 * BIT));
         if (trial <= root_cur.rem) begin
            root_in.rem       = root_cur.rem - trial;
            root_in.root[BIT] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rvld_ff[j+1] <= 1'b0;
         end else if (en) begin
            rvld_ff[j+1] <= vld_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j+1]  <= root_in;
            rside_ff[j+1] <= side_cur;
         end
      end
   end

   logic [W_BITS:0]          zround;
   logic [DISTANCE_BITS-1:0] z_in, z_ff;
   tof_side_type             zside_ff;
   logic                     zvld_ff;

   always_comb begin
      zround = ((W_BITS+1)'(root_ff[W_BITS].root) + (W_BITS+1)'(1)) >> 1;
      if (rside_ff[W_BITS].mode) begin
         z_in = rside_ff[W_BITS].range_mm;
      end else if (zround > (W_BITS+1)'(rside_ff[W_BITS].range_mm)) begin
         z_in = rside_ff[W_BITS].range_mm;
      end else begin
         z_in = zround[DISTANCE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zvld_ff <= 1'b0;
      end else if (en) begin
         zvld_ff <= rvld_ff[W_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff     <= z_in;
         zside_ff <= rside_ff[W_BITS];
      end
   end

   assign out_valid = zvld_ff;
   assign out_side  = zside_ff;
   assign out_z     = z_ff;

   `TOF_NEVER(a_z_above_dist, zvld_ff && (z_ff > zside_ff.range_mm))
   `TOF_ASSERT(a_depth_mode_pass, zvld_ff && zside_ff.mode |-> z_ff == zside_ff.range_mm)
endmodule
`default_nettype wire

// ===== hw/rtl/tof_scale.sv =====
// Lateral scaling: offset times depth over focal length, rounded and saturated, two lanes
`default_nettype none
module tof_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  tof_pkg::tof_side_type             in_side,
   input  logic [tof_pkg::DISTANCE_BITS-1:0] in_z,
   output logic                              out_valid,
   output tof_pkg::tof_rsp_type              out_data
);
   import tof_pkg::*;
`include "tof_range_to_point_unit_assert.svh"

   localparam logic [OUT_BITS-1:0] POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] NEG_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   typedef struct packed {
      logic [ACC_BITS-1:0] rem;
      logic [OUT_BITS-1:0] quo;
      logic                ovf;
   } lane_type;

   typedef struct packed {
      logic [REG_BITS:0]        den;
      logic [DISTANCE_BITS-1:0] z;
      logic                     neg_x;
      logic                     neg_y;
   } carry_type;

   // stage a: products
   logic [MAG_BITS-1:0]      mag [2];
   logic [P_BITS-1:0]        prod_in [2];
   logic [P_BITS-1:0]        prod_ff [2];
   carry_type                acar_in, acar_ff;
   logic                     avld_ff;

   // stage b and the quotient stages
   lane_type                 ln_in  [2];
   lane_type                 ln_ff  [0:OUT_BITS][2];
   carry_type                car_ff [0:OUT_BITS];
   logic                     vld_ff [0:OUT_BITS];
   logic [N_BITS-1:0]        num [2];

   always_comb begin
      mag[0]        = in_side.mag_x;
      mag[1]        = in_side.mag_y;
      prod_in[0]    = mag[0] * in_z;
      prod_in[1]    = mag[1] * in_z;
      acar_in.den   = {in_side.focal, 1'b0};
      acar_in.z     = in_z;
      acar_in.neg_x = in_side.neg_x;
      acar_in.neg_y = in_side.neg_y;
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         num[l]       = N_BITS'({prod_ff[l], 1'b0}) + N_BITS'(acar_ff.den[REG_BITS:1]);
         ln_in[l].rem = ACC_BITS'(num[l]);
         ln_in[l].quo = '0;
         ln_in[l].ovf = ACC_BITS'(num[l]) >= (ACC_BITS'(acar_ff.den) << OUT_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avld_ff   <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         avld_ff   <= in_valid;
         vld_ff[0] <= avld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         acar_ff    <= acar_in;
         ln_ff[0]   <= ln_in;
         car_ff[0]  <= acar_ff;
      end
   end

   for (genvar k = 0; k < OUT_BITS; k++) begin : g_div
      localparam int BIT = OUT_BITS - 1 - k;
      lane_type            step_in [2];
      logic [ACC_BITS-1:0] shifted;
      always_comb begin
         shifted = ACC_BITS'(car_ff[k].den) << BIT;
         for (int l = 0; l < 2; l++) begin
            step_in[l] = ln_ff[k][l];
            if (shifted <= ln_ff[k][l].rem) begin
               step_in[l].rem      = ln_ff[k][l].rem - shifted;
               step_in[l].quo[BIT] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ln_ff[k+1]  <= step_in;
            car_ff[k+1] <= car_ff[k];
         end
      end
   end

   logic                neg [2];
   logic [OUT_BITS-1:0] quo [2];
   logic [OUT_BITS-1:0] val [2];
   tof_rsp_type         rsp_in, rsp_ff;
   logic                rsp_vld_ff;

   always_comb begin
      neg[0] = car_ff[OUT_BITS].neg_x;
      neg[1] = car_ff[OUT_BITS].neg_y;
      for (int l = 0; l < 2; l++) begin
         quo[l] = ln_ff[OUT_BITS][l].quo;
         if (neg[l]) begin
            val[l] = (ln_ff[OUT_BITS][l].ovf || (quo[l] > NEG_MIN)) ? NEG_MIN : -quo[l];
         end else begin
            val[l] = (ln_ff[OUT_BITS][l].ovf || quo[l][OUT_BITS-1]) ? POS_MAX : quo[l];
         end
      end
      rsp_in.point_x = val[0];
      rsp_in.point_y = val[1];
      rsp_in.point_z = car_ff[OUT_BITS].z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vld_ff[OUT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_vld_ff;
   assign out_data  = rsp_ff;

   `TOF_ASSERT(a_zero_depth_origin, rsp_vld_ff && (rsp_ff.point_z == '0) |-> (rsp_ff.point_x == '0) && (rsp_ff.point_y == '0))
endmodule
`default_nettype wire

// ===== sim/tof_range_to_point_checker.sv =====
// Checker: watches both channels and the register port, predicts each point and compares
`timescale 1ns / 100ps
`default_nettype none
module tof_range_to_point_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  tof_pkg::tof_req_type               req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  tof_pkg::tof_rsp_type               rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tof_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tof_pkg::REG_BITS-1:0]       csr_wr_data,
   output int                                 fail_count,
   output int                                 points_pending
);
   import tof_pkg::*;

   logic [REG_BITS-1:0] focal_q, ccol_q, crow_q;
   logic                mode_q;
   tof_rsp_type         point_queue[$];

   assign points_pending = point_queue.size();

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic longint scale_offset(input longint off, input longint z, input longint f);
      longint mag, q;
      mag = (off < 0) ? -off : off;
      q = (mag * z * 2 + f) / (2 * f);
      if (off < 0) return (q > 8388608) ? -8388608 : -q;
      return (q > 8388607) ? 8388607 : q;
   endfunction

   function automatic tof_rsp_type project_point(input tof_req_type px);
      longint f, du, dv, z, c, t, r;
      logic [127:0] lhs, rhs, s, ff;
      tof_rsp_type res;
      f  = (focal_q == 0) ? 1 : longint'(focal_q);
      du = (longint'(px.pixel_col) << 8) - longint'(ccol_q);
      dv = (longint'(px.pixel_row) << 8) - longint'(crow_q);
      r  = px.distance;
      if (mode_q) z = r;
      else begin
         s  = 128'(f * f + du * du + dv * dv);
         ff = 128'(f * f);
         rhs = 128'(4 * r * r) * ff;
         z = 0;
         for (int b = DISTANCE_BITS; b >= 0; b--) begin
            c = z | (longint'(1) << b);
            t = 2 * c - 1;
            lhs = 128'(t * t) * s;
            if (lhs <= rhs) z = c;
         end
         if (z > r) z = r;
      end
      res.point_x = OUT_BITS'(scale_offset(du, z, f));
      res.point_y = OUT_BITS'(scale_offset(dv, z, f));
      res.point_z = DISTANCE_BITS'(z);
      return res;
   endfunction

   always @(posedge clock) begin
      tof_rsp_type want;
      if (reset) begin
         focal_q <= FOCAL_RESET;
         ccol_q  <= CCOL_RESET;
         crow_q  <= CROW_RESET;
         mode_q  <= 1'b0;
         point_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en)
            case (tof_csr_type'(csr_index))
               CSR_FOCAL: focal_q <= csr_wr_data;
               CSR_CCOL:  ccol_q  <= csr_wr_data;
               CSR_CROW:  crow_q  <= csr_wr_data;
               CSR_MODE:  mode_q  <= csr_wr_data[0];
               default: ;
            endcase
         if (req_valid && !req_stall) point_queue.push_back(project_point(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (point_queue.size() == 0) report_mismatch("unexpected item", 0, 0);
            else begin
               want = point_queue.pop_front();
               if (rsp_data.point_x !== want.point_x)
                  report_mismatch("point_x", rsp_data.point_x, want.point_x);
               if (rsp_data.point_y !== want.point_y)
                  report_mismatch("point_y", rsp_data.point_y, want.point_y);
               if (rsp_data.point_z !== want.point_z)
                  report_mismatch("point_z", rsp_data.point_z, want.point_z);
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== sim/tof_range_to_point_unit_tb.sv =====
// Testbench top: drives pixels and register writes through idling and stalling phases, gives the verdict
`timescale 1ns / 100ps
`default_nettype none
module tof_range_to_point_unit_tb;
   import tof_pkg::*;

   localparam int LATENCY     = 3 * DISTANCE_BITS + OUT_BITS + 11;
   localparam int CYCLE_LIMIT = 400000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0, req_stall;
   tof_req_type               req_data = '0;
   logic                      rsp_valid, rsp_stall = 1'b0;
   tof_rsp_type               rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [REG_BITS-1:0]       csr_wr_data = '0;
   int                        fail_count, points_pending;
   int                        cycle_count = 0;
   int                        stall_pct = 0;

   always #5 clock = ~clock;

   tof_range_to_point_unit uut (.*);
   tof_range_to_point_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_pixel(input tof_req_type px, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input tof_csr_type idx, input logic [REG_BITS-1:0] val);
      req_valid   <= 1'b0;
      while (points_pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic tof_req_type random_pixel();
      tof_req_type px;
      px.pixel_col = PIXEL_BITS'($urandom_range(99) < 70 ? $urandom_range(200) : $urandom);
      px.pixel_row = PIXEL_BITS'($urandom_range(99) < 70 ? $urandom_range(200) : $urandom);
      px.distance  = DISTANCE_BITS'($urandom_range(99) < 10 ? 32'hFFFF - $urandom_range(3)
                                                            : $urandom);
      return px;
   endfunction

   int send_idle[4]  = '{0, 49, 0, 14};
   int recv_stall[4] = '{0, 0, 49, 14};

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: corners in radial mode with reset registers
      send_pixel('{12'd0, 12'd0, 16'd0}, 0);
      send_pixel('{12'd88, 12'd72, 16'd1000}, 0);
      send_pixel('{12'd0, 12'd0, 16'hFFFF}, 0);
      send_pixel('{12'hFFF, 12'hFFF, 16'hFFFF}, 0);
      send_pixel('{12'hFFF, 12'd0, 16'd1}, 0);
      send_pixel('{12'd0, 12'hFFF, 16'd2}, 0);
      write_reg(CSR_MODE, 20'd1);
      send_pixel('{12'hFFF, 12'hFFF, 16'hFFFF}, 0);
      send_pixel('{12'd0, 12'd0, 16'hFFFF}, 0);
      send_pixel('{12'd100, 12'd50, 16'd0}, 0);
      write_reg(CSR_FOCAL, 20'd0);
      send_pixel('{12'hFFF, 12'd0, 16'hFFFF}, 0);
      send_pixel('{12'd0, 12'hFFF, 16'd7}, 0);
      write_reg(CSR_MODE, 20'd0);
      send_pixel('{12'd1, 12'd2, 16'hFFFF}, 0);
      write_reg(CSR_FOCAL, 20'hFFFFF);
      write_reg(CSR_CCOL, 20'hFFFFF);
      write_reg(CSR_CROW, 20'd0);
      send_pixel('{12'd0, 12'hFFF, 16'hFFFF}, 0);
      send_pixel('{12'hFFF, 12'd0, 16'd3}, 0);
      write_reg(CSR_CCOL, 20'd0);
      write_reg(CSR_CROW, 20'hFFFFF);
      send_pixel('{12'hFFF, 12'hFFF, 16'hFFFF}, 0);
      send_pixel('{12'd0, 12'd0, 16'h8000}, 0);
      // random phases, each with its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_FOCAL, ph == 7 ? 20'd1 : 20'($urandom_range(256, 300000)));
         write_reg(CSR_CCOL, ph == 6 ? 20'hFFFFF : 20'($urandom_range(0, 60000)));
         write_reg(CSR_CROW, ph == 6 ? 20'd0 : 20'($urandom_range(0, 60000)));
         write_reg(CSR_MODE, 20'(ph % 2));
         stall_pct = recv_stall[ph % 4];
         for (int n = 0; n < 66; n++) send_pixel(random_pixel(), send_idle[ph % 4]);
         req_valid <= 1'b0;
         stall_pct = 0;
      end
      req_valid <= 1'b0;
      while (points_pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tof_pkg.sv
hw/rtl/tof_front.sv
hw/rtl/tof_zsolve.sv
hw/rtl/tof_scale.sv
hw/rtl/tof_range_to_point_unit.sv
sim/tof_range_to_point_checker.sv
sim/tof_range_to_point_unit_tb.sv
